/* hdl/mld_pkg.sv */
// shared constants, types and address helper for the lcs diff block
package mld_pkg;

    localparam int MAX_LEN      = 32;
    localparam int SYMBOL_WIDTH = 32;

    localparam int IDX_W  = $clog2(MAX_LEN);
    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int XW     = LEN_W + 1;
    localparam int KW     = $clog2(2 * MAX_LEN + 2) + 1;
    localparam int YW     = KW + 1;
    localparam int KOFF   = 2 * MAX_LEN + 1;
    localparam int KSPAN  = 2 * KOFF + 1;
    localparam int ROWS   = 2 * MAX_LEN + 2;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int DDEPTH = ROWS * KSPAN;
    localparam int DA_W   = $clog2(DDEPTH);

    localparam logic [1:0] FUNC_LOAD_A = 2'd0;
    localparam logic [1:0] FUNC_LOAD_B = 2'd1;
    localparam logic [1:0] FUNC_START  = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_K0,
        S_K1,
        S_K2,
        S_SN0,
        S_SN1,
        S_WR,
        S_B0,
        S_B1,
        S_B2,
        S_B3,
        S_B4,
        S_FIN,
        S_E0,
        S_E1,
        S_E2,
        S_EMPTY
    } t_state;

    function automatic logic [DA_W-1:0] f_diag_addr(input logic [ROW_W-1:0] row,
                                                    input logic signed [KW-1:0] k);
        logic [KW:0] kidx;
        kidx = {k[KW-1], k} + (KW + 1)'(KOFF);
        return DA_W'(row * KSPAN) + DA_W'(kidx);
    endfunction

endpackage

/* hdl/mld_ram.sv */
// generic single write port ram with registered read
module mld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/myers_lcs_diff.sv */
// top level of the myers o(nd) longest common subsequence block
// Load transfers (func 0 and 1) give no result; symbols past MAX_LEN are dropped and
// flagged. A start transfer runs the greedy diagonal search, then walks back and streams
// the matched pairs in ascending order, last one marked. The diagonal memory and the
// symbol memories each have a single read port. The block is not ready for input from
// the start transfer until the final result is loaded for output.
module myers_lcs_diff
    import mld_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_symbol,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_pair_valid,
    output logic [4:0]  o_first_index,
    output logic [4:0]  o_second_index,
    output logic [31:0] o_matched_symbol,
    output logic        o_overflowed,
    output logic        o_last
);

    t_state r_state, n_state;
    logic [LEN_W-1:0]     r_n, n_n, r_m, n_m, r_cnt, n_cnt;
    logic                 r_ovf, n_ovf;
    logic signed [KW-1:0] r_d, n_d, r_k, n_k;
    logic [XW-1:0]        r_x, n_x, r_up, n_up, r_xs, n_xs;
    logic signed [YW-1:0] r_y, n_y;
    logic [IDX_W-1:0]     r_idx, n_idx;

    logic                    r_ov, n_ov;
    logic                    r_opv, n_opv, r_olast, n_olast;
    logic [4:0]              r_ofi, n_ofi, r_osi, n_osi;
    logic [31:0]             r_osym, n_osym;
    logic                    r_oovf, n_oovf;

    logic                    a_we, b_we, d_we, p_we;
    logic [IDX_W-1:0]        a_raddr, b_raddr, p_waddr;
    logic [SYMBOL_WIDTH-1:0] a_rdata, b_rdata;
    logic [DA_W-1:0]         d_waddr, d_raddr;
    logic [XW-1:0]           d_rdata, d_val;
    logic [2*IDX_W-1:0]      p_wdata, p_rdata;

    logic                 accept;
    logic [XW-1:0]        x_sel;
    logic signed [KW-1:0] row_sel;

    mld_ram #(.WIDTH(SYMBOL_WIDTH), .DEPTH(MAX_LEN)) u_seq_a (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(r_n[IDX_W-1:0]),
        .i_wdata(SYMBOL_WIDTH'(i_symbol)), .i_raddr(a_raddr), .o_rdata(a_rdata)
    );

    mld_ram #(.WIDTH(SYMBOL_WIDTH), .DEPTH(MAX_LEN)) u_seq_b (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(r_m[IDX_W-1:0]),
        .i_wdata(SYMBOL_WIDTH'(i_symbol)), .i_raddr(b_raddr), .o_rdata(b_rdata)
    );

    mld_ram #(.WIDTH(XW), .DEPTH(DDEPTH)) u_diag (
        .i_clk(i_clk), .i_we(d_we), .i_waddr(d_waddr),
        .i_wdata(r_x), .i_raddr(d_raddr), .o_rdata(d_rdata)
    );

    mld_ram #(.WIDTH(2 * IDX_W), .DEPTH(MAX_LEN)) u_stack (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_waddr),
        .i_wdata(p_wdata), .i_raddr(r_idx), .o_rdata(p_rdata)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // round zero reads as all zero
    assign row_sel = (r_state == S_B0 || r_state == S_B1 || r_state == S_B2 ||
                      r_state == S_B3 || r_state == S_B4) ? r_d : r_d;
    assign d_val   = (row_sel == '0) ? '0 : d_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n     <= '0;
            r_m     <= '0;
            r_ovf   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_m     <= n_m;
            r_ovf   <= n_ovf;
            r_ov    <= n_ov;
        end
        r_d     <= n_d;
        r_k     <= n_k;
        r_x     <= n_x;
        r_y     <= n_y;
        r_up    <= n_up;
        r_xs    <= n_xs;
        r_cnt   <= n_cnt;
        r_idx   <= n_idx;
        r_opv   <= n_opv;
        r_olast <= n_olast;
        r_ofi   <= n_ofi;
        r_osi   <= n_osi;
        r_osym  <= n_osym;
        r_oovf  <= n_oovf;
    end

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_m     = r_m;
        n_ovf   = r_ovf;
        n_d     = r_d;
        n_k     = r_k;
        n_x     = r_x;
        n_y     = r_y;
        n_up    = r_up;
        n_xs    = r_xs;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_ov    = r_ov && !i_out_ready;
        n_opv   = r_opv;
        n_olast = r_olast;
        n_ofi   = r_ofi;
        n_osi   = r_osi;
        n_osym  = r_osym;
        n_oovf  = r_oovf;
        a_we    = 1'b0;
        b_we    = 1'b0;
        d_we    = 1'b0;
        p_we    = 1'b0;
        a_raddr = r_x[IDX_W-1:0];
        b_raddr = r_y[IDX_W-1:0];
        d_raddr = f_diag_addr(ROW_W'(r_d), r_k + KW'(1));
        d_waddr = f_diag_addr(ROW_W'(r_d + KW'(1)), r_k);
        p_waddr = r_cnt[IDX_W-1:0];
        p_wdata = {IDX_W'(r_x - XW'(1)), IDX_W'(r_y - YW'(1))};
        x_sel   = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_func)
                        FUNC_LOAD_A: begin
                            if (r_n < LEN_W'(MAX_LEN)) begin
                                a_we = 1'b1;
                                n_n  = r_n + LEN_W'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        FUNC_LOAD_B: begin
                            if (r_m < LEN_W'(MAX_LEN)) begin
                                b_we = 1'b1;
                                n_m  = r_m + LEN_W'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        FUNC_START: begin
                            n_d     = '0;
                            n_k     = '0;
                            n_cnt   = '0;
                            n_state = S_K0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_K0: begin
                d_raddr = f_diag_addr(ROW_W'(r_d), r_k + KW'(1));
                n_state = S_K1;
            end
            S_K1: begin
                d_raddr = f_diag_addr(ROW_W'(r_d), r_k - KW'(1));
                n_up    = d_val;
                n_state = S_K2;
            end
            S_K2: begin
                if (r_k == -r_d || (r_k != r_d && d_val < r_up)) begin
                    x_sel = r_up;
                end else begin
                    x_sel = d_val + XW'(1);
                end
                n_x     = x_sel;
                n_y     = $signed(YW'(x_sel)) - YW'(r_k);
                n_state = S_SN0;
            end
            S_SN0: begin
                a_raddr = r_x[IDX_W-1:0];
                b_raddr = r_y[IDX_W-1:0];
                if (r_x < XW'(r_n) && r_y >= 0 && r_y < $signed(YW'(r_m))) begin
                    n_state = S_SN1;
                end else begin
                    n_state = S_WR;
                end
            end
            S_SN1: begin
                if (a_rdata == b_rdata) begin
                    n_x     = r_x + XW'(1);
                    n_y     = r_y + YW'(1);
                    n_state = S_SN0;
                end else begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                d_we = 1'b1;
                if (r_x >= XW'(r_n) && r_y >= $signed(YW'(r_m))) begin
                    n_k     = KW'(r_n) - KW'(r_m);
                    n_x     = XW'(r_n);
                    n_y     = YW'(r_m);
                    n_state = S_B0;
                end else if (r_k + KW'(2) > r_d) begin
                    n_d     = r_d + KW'(1);
                    n_k     = -(r_d + KW'(1));
                    n_state = S_K0;
                end else begin
                    n_k     = r_k + KW'(2);
                    n_state = S_K0;
                end
            end
            S_B0: begin
                d_raddr = f_diag_addr(ROW_W'(r_d), r_k + KW'(1));
                n_state = S_B1;
            end
            S_B1: begin
                d_raddr = f_diag_addr(ROW_W'(r_d), r_k - KW'(1));
                n_up    = d_val;
                n_state = S_B2;
            end
            S_B2: begin
                if (r_k == -r_d || (r_k != r_d && d_val < r_up)) begin
                    n_xs = r_up;
                    n_k  = r_k + KW'(1);
                end else begin
                    n_xs = d_val + XW'(1);
                    n_k  = r_k - KW'(1);
                end
                n_state = S_B3;
            end
            S_B3: begin
                d_raddr = f_diag_addr(ROW_W'(r_d), r_k);
                if (r_x > r_xs) begin
                    n_x = r_x - XW'(1);
                    n_y = r_y - YW'(1);
                    if (r_cnt < LEN_W'(MAX_LEN) && r_y >= $signed(YW'(1))) begin
                        p_we  = 1'b1;
                        n_cnt = r_cnt + LEN_W'(1);
                    end
                end else begin
                    n_state = S_B4;
                end
            end
            S_B4: begin
                n_x = d_val;
                n_y = $signed(YW'(d_val)) - YW'(r_k);
                if (r_d == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_d     = r_d - KW'(1);
                    n_state = S_B0;
                end
            end
            S_FIN: begin
                if (r_cnt == '0) begin
                    n_state = S_EMPTY;
                end else begin
                    n_idx   = IDX_W'(r_cnt - LEN_W'(1));
                    n_state = S_E0;
                end
            end
            S_E0: begin
                n_state = S_E1;
            end
            S_E1: begin
                a_raddr = p_rdata[2*IDX_W-1:IDX_W];
                n_state = S_E2;
            end
            S_E2: begin
                a_raddr = p_rdata[2*IDX_W-1:IDX_W];
                if (!r_ov || i_out_ready) begin
                    n_ov    = 1'b1;
                    n_opv   = 1'b1;
                    n_ofi   = 5'(p_rdata[2*IDX_W-1:IDX_W]);
                    n_osi   = 5'(p_rdata[IDX_W-1:0]);
                    n_osym  = 32'(a_rdata);
                    n_oovf  = r_ovf;
                    n_olast = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_n     = '0;
                        n_m     = '0;
                        n_ovf   = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx - IDX_W'(1);
                        n_state = S_E0;
                    end
                end
            end
            S_EMPTY: begin
                if (!r_ov || i_out_ready) begin
                    n_ov    = 1'b1;
                    n_opv   = 1'b0;
                    n_ofi   = '0;
                    n_osi   = '0;
                    n_osym  = '0;
                    n_oovf  = r_ovf;
                    n_olast = 1'b1;
                    n_n     = '0;
                    n_m     = '0;
                    n_ovf   = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid      = r_ov;
    assign o_pair_valid     = r_opv;
    assign o_first_index    = r_ofi;
    assign o_second_index   = r_osi;
    assign o_matched_symbol = r_osym;
    assign o_overflowed     = r_oovf;
    assign o_last           = r_olast;

endmodule

/* verif/tb_top.sv */
// self-checking testbench for the myers lcs diff block: directed table then random jobs
module tb_top;
    import mld_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        pair_valid;
        logic [4:0]  first_index;
        logic [4:0]  second_index;
        logic [31:0] matched_symbol;
        logic        overflowed;
        logic        last;
    } t_pair;

    typedef struct {
        logic [1:0]  func;
        logic [31:0] symbol;
        logic        has_exp;
        t_pair       exp;
    } t_row;

    logic        i_clk, i_rst_n, i_in_valid, i_out_ready;
    logic [1:0]  i_func;
    logic [31:0] i_symbol;
    logic        o_in_ready, o_out_valid, o_pair_valid, o_overflowed, o_last;
    logic [4:0]  o_first_index, o_second_index;
    logic [31:0] o_matched_symbol;

    myers_lcs_diff uut (.*);

    logic [31:0] seq_a [MAX_LEN];
    logic [31:0] seq_b [MAX_LEN];
    int          len_a, len_b;
    logic        ovf;
    t_pair       pair_queue[$];
    int          errors;
    int          quiet;
    logic        calm;
    int          lcs_tab [MAX_LEN+1][MAX_LEN+1];

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // myers search with backtrack, same tie rules as the block
    task automatic predict_lcs();
        int v [ROWS][KSPAN];
        int n, m, d, k, x, y, up, dn, kk, dd, xs, cnt;
        int px [MAX_LEN];
        int py [MAX_LEN];
        bit done;
        t_pair p;
        n = len_a; m = len_b; cnt = 0; done = 0;
        for (int r = 0; r < ROWS; r++) for (int c = 0; c < KSPAN; c++) v[r][c] = 0;
        for (d = 0; d <= n + m && !done; d++) begin
            for (k = -d; k <= d && !done; k += 2) begin
                up = v[d][k+1+KOFF]; dn = v[d][k-1+KOFF];
                x = (k == -d || (k != d && dn < up)) ? up : dn + 1;
                y = x - k;
                while (x < n && y >= 0 && y < m && seq_a[x] == seq_b[y]) begin
                    x++; y++;
                end
                v[d+1][k+KOFF] = x;
                if (x >= n && y >= m) begin
                    kk = n - m; dd = d; x = n; y = m;
                    while (dd >= 0) begin
                        up = v[dd][kk+1+KOFF]; dn = v[dd][kk-1+KOFF];
                        if (kk == -dd || (kk != dd && dn < up)) begin
                            xs = up; kk++;
                        end else begin
                            xs = dn + 1; kk--;
                        end
                        while (x > xs) begin
                            x--; y--;
                            if (cnt < MAX_LEN && x >= 0 && y >= 0) begin
                                px[cnt] = x; py[cnt] = y; cnt++;
                            end
                        end
                        x = v[dd][kk+KOFF];
                        y = x - kk;
                        dd--;
                    end
                    done = 1;
                end
            end
        end
        if (cnt == 0) begin
            p = '{1'b0, 5'd0, 5'd0, 32'd0, ovf, 1'b1};
            pair_queue.push_back(p);
        end else begin
            for (int i = 0; i < cnt; i++) begin
                p.pair_valid = 1'b1;
                p.first_index = px[cnt-1-i][4:0];
                p.second_index = py[cnt-1-i][4:0];
                p.matched_symbol = seq_a[px[cnt-1-i]];
                p.overflowed = ovf;
                p.last = (i == cnt - 1);
                pair_queue.push_back(p);
            end
        end
        len_a = 0; len_b = 0; ovf = 0;
    endtask

    task automatic apply_item(input logic [1:0] f, input logic [31:0] s);
        case (f)
            FUNC_LOAD_A: begin
                if (len_a < MAX_LEN) seq_a[len_a++] = s; else ovf = 1;
            end
            FUNC_LOAD_B: begin
                if (len_b < MAX_LEN) seq_b[len_b++] = s; else ovf = 1;
            end
            FUNC_START: predict_lcs();
            default: ;
        endcase
    endtask

    task automatic send(input logic [1:0] f, input logic [31:0] s);
        while (!calm && $urandom_range(99) < 6) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= f;
        i_symbol <= s;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        apply_item(f, s);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_sym(input int alpha);
        case ($urandom_range(9))
            0: return 32'hFFFF_FFFF;
            1: return $urandom();
            default: return 32'(alpha == 0 ? 0 : $urandom_range(alpha));
        endcase
    endfunction

    // output side
    always @(posedge i_clk) begin
        t_pair e;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pair_queue.size() == 0) begin
                    $error("unexpected transfer");
                    errors++;
                end else begin
                    e = pair_queue.pop_front();
                    if (o_pair_valid !== e.pair_valid) begin
                        $error("pair_valid exp %0h got %0h", e.pair_valid, o_pair_valid);
                        errors++;
                    end
                    if (o_first_index !== e.first_index) begin
                        $error("first_index exp %0d got %0d", e.first_index, o_first_index);
                        errors++;
                    end
                    if (o_second_index !== e.second_index) begin
                        $error("second_index exp %0d got %0d", e.second_index,
                               o_second_index);
                        errors++;
                    end
                    if (o_matched_symbol !== e.matched_symbol) begin
                        $error("matched_symbol exp %0h got %0h", e.matched_symbol,
                               o_matched_symbol);
                        errors++;
                    end
                    if (o_overflowed !== e.overflowed) begin
                        $error("overflowed exp %0h got %0h", e.overflowed, o_overflowed);
                        errors++;
                    end
                    if (o_last !== e.last) begin
                        $error("last exp %0h got %0h", e.last, o_last);
                        errors++;
                    end
                end
            end
        end
    end

    always @(negedge i_clk) i_out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 6);

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 200000) begin
            $display("[myers_lcs_diff] ERROR");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        t_row r;
        int na, nb, alpha;
        errors = 0; quiet = 0; calm = 0;
        len_a = 0; len_b = 0; ovf = 0;
        i_rst_n = 0; i_in_valid = 0; i_func = FUNC_LOAD_A; i_symbol = 0; i_out_ready = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // empty sequences after reset: one empty result
        rows.push_back('{FUNC_START, 32'h0, 1'b1, '{1'b0, 5'd0, 5'd0, 32'd0, 1'b0, 1'b1}});
        // single match at extreme value
        rows.push_back('{FUNC_LOAD_A, 32'hFFFF_FFFF, 1'b0, '0});
        rows.push_back('{FUNC_LOAD_B, 32'hFFFF_FFFF, 1'b0, '0});
        rows.push_back('{FUNC_START, 32'h0, 1'b1,
                         '{1'b1, 5'd0, 5'd0, 32'hFFFF_FFFF, 1'b0, 1'b1}});
        // unused code ignored, then mismatch gives empty result
        rows.push_back('{2'd3, 32'h1234_5678, 1'b0, '0});
        rows.push_back('{FUNC_LOAD_A, 32'h0, 1'b0, '0});
        rows.push_back('{FUNC_LOAD_B, 32'h5555_AAAA, 1'b0, '0});
        rows.push_back('{FUNC_START, 32'hFFFF_FFFF, 1'b1,
                         '{1'b0, 5'd0, 5'd0, 32'd0, 1'b0, 1'b1}});
        // one side empty
        rows.push_back('{FUNC_LOAD_B, 32'h7, 1'b0, '0});
        rows.push_back('{FUNC_START, 32'h0, 1'b1, '{1'b0, 5'd0, 5'd0, 32'd0, 1'b0, 1'b1}});
        // small mixed job checked by the predictor
        rows.push_back('{FUNC_LOAD_A, 32'h1, 1'b0, '0});
        rows.push_back('{FUNC_LOAD_A, 32'h2, 1'b0, '0});
        rows.push_back('{FUNC_LOAD_A, 32'h3, 1'b0, '0});
        rows.push_back('{FUNC_LOAD_B, 32'h2, 1'b0, '0});
        rows.push_back('{FUNC_LOAD_B, 32'h3, 1'b0, '0});
        rows.push_back('{FUNC_LOAD_B, 32'h1, 1'b0, '0});
        rows.push_back('{FUNC_START, 32'h0, 1'b0, '0});

        foreach (rows[i]) begin
            r = rows[i];
            send(r.func, r.symbol);
            if (r.has_exp && r.func == FUNC_START) begin
                if (pair_queue.size() == 0 || pair_queue[pair_queue.size()-1] !== r.exp) begin
                    $error("table row %0d expectation differs from predictor", i);
                    errors++;
                end
            end
        end

        // full sequences with overflow on both sides
        for (int i = 0; i < MAX_LEN + 1; i++) send(FUNC_LOAD_A, pick_sym(3));
        for (int i = 0; i < MAX_LEN + 1; i++) send(FUNC_LOAD_B, pick_sym(3));
        send(FUNC_START, 32'h0);

        // random jobs, mostly small
        for (int job = 0; job < 20; job++) begin
            calm = (job >= 10 && job < 15);
            if ($urandom_range(9) == 0) begin
                na = $urandom_range(MAX_LEN); nb = $urandom_range(MAX_LEN);
            end else begin
                na = $urandom_range(6); nb = $urandom_range(6);
            end
            alpha = $urandom_range(3);
            while (na + nb > 0) begin
                if ($urandom_range(29) == 0) send(2'd3, $urandom());
                if (nb == 0 || (na > 0 && $urandom_range(1))) begin
                    send(FUNC_LOAD_A, pick_sym(alpha)); na--;
                end else begin
                    send(FUNC_LOAD_B, pick_sym(alpha)); nb--;
                end
            end
            send(FUNC_START, $urandom());
        end
        calm = 0;
        i_in_valid <= 1'b0;

        while (pair_queue.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("[myers_lcs_diff] OK");
        end else begin
            $display("[myers_lcs_diff] ERROR");
        end
        $finish;
    end
endmodule

/* sim.f */
hdl/mld_pkg.sv
hdl/mld_ram.sv
hdl/myers_lcs_diff.sv
verif/tb_top.sv
